// ----- rtl/adt_pkg.sv -----
package adt_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int VTX_W = 6;
  localparam int VCOUNT_W = 7;
  localparam int TOTAL_W = 12;
  localparam int DEG_W = 6;
  localparam int DEG_MAX = 63;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_RANGE     = 2'd1,
    STS_SELF_LOOP = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [VTX_W-1:0] vertex_from;
    logic [VTX_W-1:0] vertex_to;
  } adt_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               arc_present;
    logic [TOTAL_W-1:0] arc_total;
    logic [DEG_W-1:0]   out_degree;
    logic [DEG_W-1:0]   in_degree;
  } adt_res_t;

endpackage

// ----- rtl/adt_ifs.sv -----
interface adt_cmd_if import adt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [VTX_W-1:0] vertex_from;
  logic [VTX_W-1:0] vertex_to;

  modport source (output valid, command, vertex_from, vertex_to, input ready);
  modport sink (input valid, command, vertex_from, vertex_to, output ready);
endinterface

interface adt_res_if import adt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               arc_present;
  logic [TOTAL_W-1:0] arc_total;
  logic [DEG_W-1:0]   out_degree;
  logic [DEG_W-1:0]   in_degree;

  modport source (output valid, status, arc_present, arc_total, out_degree, in_degree,
                  input ready);
  modport sink (input valid, status, arc_present, arc_total, out_degree, in_degree,
                output ready);
endinterface

interface adt_cfg_if import adt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VCOUNT_W-1:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

// ----- rtl/adt_matrix.sv -----
module adt_matrix import adt_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  adt_req_t            req_i,
  input  logic [VCOUNT_W-1:0] vcount_i,
  output adt_res_t            res_o
);

  // Vertex numbers are 6 bits wide, so rows beyond 64 could never be reached.
  localparam int NV = (MAX_VERTICES < (1 << VTX_W)) ? MAX_VERTICES : (1 << VTX_W);
  localparam int IW = $clog2(NV);
  localparam int CW = $clog2(NV + 1);

  logic [NV-1:0]      mat_q [NV];
  logic [TOTAL_W-1:0] arc_q;
  logic [TOTAL_W-1:0] arc_d;

  logic               in_range;
  logic [IW-1:0]      fi;
  logic [IW-1:0]      ti;
  logic [NV-1:0]      row;
  logic [NV-1:0]      row_new;
  logic [NV-1:0]      act;
  logic               present;
  logic               do_set;
  logic               do_clr;
  logic [CW-1:0]      outd;
  logic [CW-1:0]      ind;
  logic [NV-1:0]      diag;

  always_comb begin
    in_range = ({1'b0, req_i.vertex_from} < vcount_i) &&
               ({1'b0, req_i.vertex_to} < vcount_i) &&
               (32'(req_i.vertex_from) < NV) && (32'(req_i.vertex_to) < NV);
    fi = req_i.vertex_from[IW-1:0];
    ti = req_i.vertex_to[IW-1:0];
    row = mat_q[fi];
    present = in_range && row[ti];
    do_set = in_range && (req_i.command == CMD_INSERT) && (fi != ti) && !present;
    do_clr = in_range && (req_i.command == CMD_REMOVE) && present;
    row_new = row;
    if (do_set) begin
      row_new[ti] = 1'b1;
    end else if (do_clr) begin
      row_new[ti] = 1'b0;
    end
    arc_d = arc_q;
    if (do_set) begin
      arc_d = arc_q + TOTAL_W'(1);
    end else if (do_clr) begin
      arc_d = arc_q - TOTAL_W'(1);
    end

    // Only vertices below the configured count take part in the degrees.
    // The column of the source never holds the updated bit, so the old matrix serves.
    outd = '0;
    ind = '0;
    for (int i = 0; i < NV; i++) begin
      act[i] = (i < int'(vcount_i));
      outd = outd + CW'(row_new[i] & act[i]);
      ind = ind + CW'(mat_q[i][fi] & act[i] & (i != int'(fi)));
      diag[i] = mat_q[i][i];
    end

    res_o.arc_total = arc_d;
    if (!in_range) begin
      res_o.status = STS_RANGE;
      res_o.arc_present = 1'b0;
      res_o.out_degree = '0;
      res_o.in_degree = '0;
    end else begin
      res_o.status = ((req_i.command == CMD_INSERT) && (fi == ti)) ? STS_SELF_LOOP : STS_DONE;
      res_o.arc_present = present;
      res_o.out_degree = (32'(outd) > DEG_MAX) ? DEG_W'(DEG_MAX) : DEG_W'(outd);
      res_o.in_degree = (32'(ind) > DEG_MAX) ? DEG_W'(DEG_MAX) : DEG_W'(ind);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NV; r++) begin
        mat_q[r] <= '0;
      end
      arc_q <= '0;
    end else if (en_i) begin
      mat_q[fi] <= row_new;
      arc_q <= arc_d;
    end
  end

  a_no_self_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    diag == '0)
    else $error("self-loop stored in arc matrix");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (arc_q == $past(arc_q)) || (arc_q == $past(arc_q) + TOTAL_W'(1)) ||
    (arc_q == $past(arc_q) - TOTAL_W'(1)))
    else $error("arc count moved by more than one");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(arc_q))
    else $error("arc count changed without an item");

  a_range_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !in_range) |=> $stable(arc_q))
    else $error("out-of-range item changed the graph");

endmodule

// ----- rtl/directed_adjacency_table_top.sv -----
// Channel  Direction  Transfer condition      Payload
// cmd_i    in         valid && ready          command, vertex_from, vertex_to
// res_o    out        valid && ready          status, arc_present, arc_total, degrees
// cfg_i    in         valid && ready          vertex_count
//
// One item per cycle while results are not stalled: an accepted item sits in the
// input register, where the arc matrix lookup, update and row/column popcounts are
// done, and its result is then registered and offered from the output register.
// Reset clears the arc matrix flops, the arc count and the pipeline at once.
// A stalled result holds the output register; the input register still takes one item.
// Configuration writes are always taken.
module directed_adjacency_table_top import adt_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  adt_cmd_if.sink   cmd_i,
  adt_res_if.source res_o,
  adt_cfg_if.sink   cfg_i
);

  logic                in_v_q;
  logic                in_v_d;
  logic                out_v_q;
  logic                out_v_d;
  logic [VCOUNT_W-1:0] vcount_q;
  adt_req_t            req_q;
  adt_res_t            res_q;
  adt_res_t            core_res;
  logic                adv;
  logic                in_ready;

  always_comb begin
    adv = in_v_q && (!out_v_q || res_o.ready);
    in_ready = !in_v_q || adv;
    in_v_d = in_ready ? cmd_i.valid : in_v_q;
    if (adv) begin
      out_v_d = 1'b1;
    end else if (res_o.ready) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      out_v_q <= 1'b0;
      vcount_q <= VCOUNT_RESET;
    end else begin
      in_v_q <= in_v_d;
      out_v_q <= out_v_d;
      if (cfg_i.valid) begin
        vcount_q <= cfg_i.vertex_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && in_ready) begin
      req_q.command <= cmd_i.command;
      req_q.vertex_from <= cmd_i.vertex_from;
      req_q.vertex_to <= cmd_i.vertex_to;
    end
    if (adv) begin
      res_q <= core_res;
    end
  end

  adt_matrix #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .req_i   (req_q),
    .vcount_i(vcount_q),
    .res_o   (core_res)
  );

  assign cmd_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_v_q;
  assign res_o.status = res_q.status;
  assign res_o.arc_present = res_q.arc_present;
  assign res_o.arc_total = res_q.arc_total;
  assign res_o.out_degree = res_q.out_degree;
  assign res_o.in_degree = res_q.in_degree;

endmodule
